[design/ciou_pkg.sv]
`timescale 1ns / 1ps

package ciou_pkg;

   // Default sizes
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int ATAN_STEPS_DEFAULT = 16;

   // Fixed-point constants
   localparam int FRAC_BITS     = 16;
   localparam int ONE_Q16       = 65536;
   localparam int LOSS_CAP      = 196608;
   localparam int CORDIC_GUARD  = 8;
   localparam int ANGLE_BITS    = 31;
   localparam int ANGLE_QUARTER = 1 << 30;
   localparam int TABLE_LEN     = 24;

   // atan(2^-i), 2^30 = pi/2, truncated
   localparam int ATAN_TABLE [TABLE_LEN] = '{
      536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772,
      166886, 83443, 41721, 20860, 10430, 5215,
      2607, 1303, 651, 325, 162, 81
   };

   typedef struct packed {
      logic [15:0] pred_left;
      logic [15:0] pred_top;
      logic [15:0] pred_right;
      logic [15:0] pred_bottom;
      logic [15:0] gt_left;
      logic [15:0] gt_top;
      logic [15:0] gt_right;
      logic [15:0] gt_bottom;
   } ciou_req_type;

   typedef struct packed {
      logic [16:0] overlap_ratio;
      logic [17:0] box_loss;
   } ciou_rsp_type;

endpackage

[design/ciou_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage.
// quo = floor(num * 2^FRAC_BITS / den); needs den != 0 and num < den * 2^INT_BITS.
module ciou_div import ciou_pkg::*; #(
   parameter int DW        = 33,
   parameter int INT_BITS  = 1,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [DW+INT_BITS-1:0]   num,
   input  logic [DW-1:0]            den,
   output logic [INT_BITS+FRAC_BITS-1:0] quo
);

   localparam int Q = INT_BITS + FRAC_BITS;
   localparam int W = DW + Q;

   logic [W-1:0]  r_ff [Q];
   logic [DW-1:0] d_ff [Q];
   logic [Q-1:0]  q_ff [Q];

   for (genvar k = 0; k < Q; k++) begin : g_step
      logic [W-1:0]  r_cur;
      logic [W-1:0]  trial;
      logic [DW-1:0] d_cur;
      logic [Q-1:0]  q_cur;

      if (k == 0) begin : g_first
         assign r_cur = W'(num) << FRAC_BITS;
         assign d_cur = den;
         assign q_cur = '0;
      end else begin : g_next
         assign r_cur = r_ff[k-1];
         assign d_cur = d_ff[k-1];
         assign q_cur = q_ff[k-1];
      end

      assign trial = W'(d_cur) << (Q - 1 - k);

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_cur;
            if (r_cur >= trial) begin
               r_ff[k] <= r_cur - trial;
               q_ff[k] <= q_cur | (Q'(1) << (Q - 1 - k));
            end else begin
               r_ff[k] <= r_cur;
               q_ff[k] <= q_cur;
            end
         end
      end
   end

   assign quo = q_ff[Q-1];

endmodule

[design/ciou_cordic.sv]
`timescale 1ns / 1ps

// Vectoring CORDIC, one rotation per stage plus a clamp stage.
// angle = atan2(width_in, height_in), 2^30 = pi/2.
module ciou_cordic import ciou_pkg::*; #(
   parameter int CW    = COORD_BITS_DEFAULT,
   parameter int STEPS = ATAN_STEPS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [CW-1:0]         width_in,
   input  logic [CW-1:0]         height_in,
   output logic [ANGLE_BITS-1:0] angle
);

   localparam int XW = CW + CORDIC_GUARD + 3;
   localparam int ZW = ANGLE_BITS + 2;
   localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(ANGLE_QUARTER);

   logic signed [XW-1:0] x_ff [STEPS];
   logic signed [XW-1:0] y_ff [STEPS];
   logic signed [ZW-1:0] z_ff [STEPS];
   logic                 zero_ff [STEPS];
   logic [ANGLE_BITS-1:0] angle_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      logic signed [XW-1:0] x_cur, y_cur, xs, ys;
      logic signed [ZW-1:0] z_cur;
      logic                 zero_cur;

      if (i == 0) begin : g_first
         assign x_cur    = $signed(XW'(height_in) << CORDIC_GUARD);
         assign y_cur    = $signed(XW'(width_in) << CORDIC_GUARD);
         assign z_cur    = '0;
         assign zero_cur = (width_in == '0) && (height_in == '0);
      end else begin : g_next
         assign x_cur    = x_ff[i-1];
         assign y_cur    = y_ff[i-1];
         assign z_cur    = z_ff[i-1];
         assign zero_cur = zero_ff[i-1];
      end

      assign xs = x_cur >>> i;
      assign ys = y_cur >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i] <= zero_cur;
            if (!y_cur[XW-1]) begin
               x_ff[i] <= x_cur + ys;
               y_ff[i] <= y_cur - xs;
               z_ff[i] <= z_cur + ZW'(ATAN_TABLE[i]);
            end else begin
               x_ff[i] <= x_cur - ys;
               y_ff[i] <= y_cur + xs;
               z_ff[i] <= z_cur - ZW'(ATAN_TABLE[i]);
            end
         end
      end
   end

   // clamp to [0, pi/2]; a degenerate box reads as zero
   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[STEPS-1] || z_ff[STEPS-1][ZW-1]) begin
            angle_ff <= '0;
         end else if (z_ff[STEPS-1] > Z_QUARTER) begin
            angle_ff <= ANGLE_BITS'(ANGLE_QUARTER);
         end else begin
            angle_ff <= z_ff[STEPS-1][ANGLE_BITS-1:0];
         end
      end
   end

   assign angle = angle_ff;

endmodule

[design/ciou_box_loss.sv]
`timescale 1ns / 1ps

// Channel   Ports                                Payload
// -------   ----------------------------------   -------------------------------------
// request   req_valid, req_stall, req_data       ciou_req_type: two boxes, 8 corners
// response  rsp_valid, rsp_stall, rsp_data       ciou_rsp_type: overlap_ratio, box_loss
//
// One box pair enters per clock while req_stall is low; the pipeline holds
// ALIGN + 18 stages plus the response register. Depth is set by the CORDIC
// chain and the two restoring dividers in series (IoU, then the aspect term).
// Reset clears only the valid bits and the response register's valid.
// A stalled response freezes the pipeline only when its last stage holds a
// transfer; bubbles drain meanwhile, so a new request is taken while a result waits.
module ciou_box_loss import ciou_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int ATAN_STEPS = ATAN_STEPS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ciou_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ciou_rsp_type rsp_data
);

   localparam int C        = COORD_BITS;
   localparam int AW       = 2 * C;       // area / product
   localparam int UW       = 2 * C + 1;   // union, diagonal sum
   localparam int NW       = 2 * C + 3;   // distance numerator, 4*c2
   localparam int IOU_Q    = 1 + FRAC_BITS;
   localparam int DT_Q     = 2 + FRAC_BITS;
   localparam int AT_Q     = 17;
   localparam int LAT_IOU  = 3 + IOU_Q;
   localparam int LAT_DT   = 3 + DT_Q;
   localparam int LAT_V    = ATAN_STEPS + 5;
   localparam int ALIGN    = ((LAT_V > LAT_IOU) ? LAT_V : LAT_IOU) + 1;
   localparam int LAST     = ALIGN + 1 + AT_Q;
   localparam int IOU_DLY  = ALIGN - LAT_IOU;
   localparam int V_DLY    = ALIGN - LAT_V;
   localparam int DT_DLY   = LAST - LAT_DT;

   // pipeline advance: hold only when a finished transfer is blocked behind the output
   logic adv;
   logic vld_ff [LAST];
   logic rsp_valid_ff;
   ciou_rsp_type rsp_data_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall && vld_ff[LAST-1]);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAST; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < LAST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   function automatic logic [C-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
      return (hi > lo) ? hi - lo : '0;
   endfunction

   // ---------------- stage 1: extents and centre offsets ----------------
   logic [C-1:0] px1, py1, px2, py2, gx1, gy1, gx2, gy2;
   logic [C:0]   psx, psy, gsx, gsy;
   logic [C-1:0] wp_ff, hp_ff, wg_ff, hg_ff, iw_ff, ih_ff, ew_ff, eh_ff;
   logic [C:0]   sx_ff, sy_ff;

   assign px1 = C'(req_data.pred_left);
   assign py1 = C'(req_data.pred_top);
   assign px2 = C'(req_data.pred_right);
   assign py2 = C'(req_data.pred_bottom);
   assign gx1 = C'(req_data.gt_left);
   assign gy1 = C'(req_data.gt_top);
   assign gx2 = C'(req_data.gt_right);
   assign gy2 = C'(req_data.gt_bottom);
   assign psx = (C+1)'(px1) + (C+1)'(px2);
   assign psy = (C+1)'(py1) + (C+1)'(py2);
   assign gsx = (C+1)'(gx1) + (C+1)'(gx2);
   assign gsy = (C+1)'(gy1) + (C+1)'(gy2);

   always_ff @(posedge clock) begin
      if (adv) begin
         wp_ff <= span(px1, px2);
         hp_ff <= span(py1, py2);
         wg_ff <= span(gx1, gx2);
         hg_ff <= span(gy1, gy2);
         iw_ff <= span((px1 > gx1) ? px1 : gx1, (px2 < gx2) ? px2 : gx2);
         ih_ff <= span((py1 > gy1) ? py1 : gy1, (py2 < gy2) ? py2 : gy2);
         ew_ff <= span((px1 < gx1) ? px1 : gx1, (px2 > gx2) ? px2 : gx2);
         eh_ff <= span((py1 < gy1) ? py1 : gy1, (py2 > gy2) ? py2 : gy2);
         sx_ff <= (psx > gsx) ? psx - gsx : gsx - psx;
         sy_ff <= (psy > gsy) ? psy - gsy : gsy - psy;
      end
   end

   // ---------------- stage 2: products ----------------
   logic [AW-1:0]  inter_ff, parea_ff, garea_ff, ew2_ff, eh2_ff;
   logic [AW+1:0]  sx2_ff, sy2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         inter_ff <= AW'(iw_ff) * AW'(ih_ff);
         parea_ff <= AW'(wp_ff) * AW'(hp_ff);
         garea_ff <= AW'(wg_ff) * AW'(hg_ff);
         ew2_ff   <= AW'(ew_ff) * AW'(ew_ff);
         eh2_ff   <= AW'(eh_ff) * AW'(eh_ff);
         sx2_ff   <= (AW+2)'(sx_ff) * (AW+2)'(sx_ff);
         sy2_ff   <= (AW+2)'(sy_ff) * (AW+2)'(sy_ff);
      end
   end

   // ---------------- stage 3: divider operands ----------------
   logic [UW-1:0] uni, c2;
   logic [NW-1:0] dnum, den4;
   logic          dsat;
   logic [UW:0]   iou_num_ff;
   logic [UW-1:0] iou_den_ff;
   logic [NW+1:0] dt_num_ff;
   logic [NW-1:0] dt_den_ff;
   logic          dsat_ff;

   assign uni  = UW'(parea_ff) + UW'(garea_ff) - UW'(inter_ff);
   assign c2   = UW'(ew2_ff) + UW'(eh2_ff);
   assign dnum = NW'(sx2_ff) + NW'(sy2_ff);
   assign den4 = NW'(c2) << 2;
   assign dsat = (den4 != '0) && ((NW+2)'(dnum) >= ((NW+2)'(den4) << 2));

   // empty union or diagonal, or a saturating distance: divide zero by one for a zero ratio
   always_ff @(posedge clock) begin
      if (adv) begin
         iou_num_ff <= (uni == '0) ? '0 : (UW+1)'(inter_ff);
         iou_den_ff <= (uni == '0) ? UW'(1) : uni;
         dt_num_ff  <= (den4 == '0 || dsat) ? '0 : (NW+2)'(dnum);
         dt_den_ff  <= (den4 == '0 || dsat) ? NW'(1) : den4;
         dsat_ff    <= dsat;
      end
   end

   // ---------------- IoU and distance dividers ----------------
   logic [IOU_Q-1:0] iou_q;
   logic [DT_Q-1:0]  dt_q;

   ciou_div #(.DW(UW), .INT_BITS(1), .FRAC_BITS(FRAC_BITS)) u_iou_div (
      .clock (clock),
      .en    (adv),
      .num   (iou_num_ff),
      .den   (iou_den_ff),
      .quo   (iou_q)
   );

   ciou_div #(.DW(NW), .INT_BITS(2), .FRAC_BITS(FRAC_BITS)) u_dist_div (
      .clock (clock),
      .en    (adv),
      .num   (dt_num_ff),
      .den   (dt_den_ff),
      .quo   (dt_q)
   );

   // carry the saturation flag beside the distance divider
   logic sat_dly_ff [DT_Q];
   always_ff @(posedge clock) begin
      if (adv) begin
         sat_dly_ff[0] <= dsat_ff;
         for (int k = 1; k < DT_Q; k++) sat_dly_ff[k] <= sat_dly_ff[k-1];
      end
   end

   // saturate the distance term, then hold it until the aspect term lands
   logic [17:0] dterm;
   logic [17:0] dt_dly_ff [DT_DLY];
   assign dterm = (sat_dly_ff[DT_Q-1] || dt_q > 18'(LOSS_CAP)) ? 18'(LOSS_CAP) : dt_q;

   always_ff @(posedge clock) begin
      if (adv) begin
         dt_dly_ff[0] <= dterm;
         for (int k = 1; k < DT_DLY; k++) dt_dly_ff[k] <= dt_dly_ff[k-1];
      end
   end

   // ---------------- aspect angles ----------------
   logic [ANGLE_BITS-1:0] ang_p, ang_g;

   ciou_cordic #(.CW(C), .STEPS(ATAN_STEPS)) u_cordic_pred (
      .clock     (clock),
      .en        (adv),
      .width_in  (wp_ff),
      .height_in (hp_ff),
      .angle     (ang_p)
   );

   ciou_cordic #(.CW(C), .STEPS(ATAN_STEPS)) u_cordic_gt (
      .clock     (clock),
      .en        (adv),
      .width_in  (wg_ff),
      .height_in (hg_ff),
      .angle     (ang_g)
   );

   // v = floor(d^2 / 2^44), d split into 16 high and 15 low bits
   logic [ANGLE_BITS-1:0] ang_d_ff;
   logic [31:0] p_hh_ff;
   logic [30:0] p_hl_ff;
   logic [29:0] p_ll_ff;
   logic [61:0] dsq;
   logic [16:0] v_ff;

   assign dsq = (62'(p_hh_ff) << 30) + (62'(p_hl_ff) << 16) + 62'(p_ll_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_d_ff <= (ang_g > ang_p) ? ang_g - ang_p : ang_p - ang_g;
         p_hh_ff  <= 32'(ang_d_ff[30:15]) * 32'(ang_d_ff[30:15]);
         p_hl_ff  <= 31'(ang_d_ff[30:15]) * 31'(ang_d_ff[14:0]);
         p_ll_ff  <= 30'(ang_d_ff[14:0]) * 30'(ang_d_ff[14:0]);
         v_ff     <= dsq[60:44];
      end
   end

   // ---------------- align IoU and v ----------------
   logic [16:0] iou_dly_ff [IOU_DLY];
   logic [16:0] v_dly_ff [V_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         iou_dly_ff[0] <= iou_q;
         for (int k = 1; k < IOU_DLY; k++) iou_dly_ff[k] <= iou_dly_ff[k-1];
         v_dly_ff[0] <= v_ff;
         for (int k = 1; k < V_DLY; k++) v_dly_ff[k] <= v_dly_ff[k-1];
      end
   end

   // ---------------- aspect term operands ----------------
   logic [16:0] iou_a, v_a, u_a;
   logic [17:0] aden;
   logic [34:0] at_num_ff;
   logic [17:0] at_den_ff;
   logic [16:0] u_ff, iou_ff;

   assign iou_a = iou_dly_ff[IOU_DLY-1];
   assign v_a   = v_dly_ff[V_DLY-1];
   assign u_a   = 17'(ONE_Q16) - iou_a;
   assign aden  = 18'(u_a) + 18'(v_a);

   always_ff @(posedge clock) begin
      if (adv) begin
         at_num_ff <= (aden == '0) ? '0 : 35'(34'(v_a) * 34'(v_a));
         at_den_ff <= (aden == '0) ? 18'(1) : aden;
         u_ff      <= u_a;
         iou_ff    <= iou_a;
      end
   end

   logic [AT_Q-1:0] aterm;

   ciou_div #(.DW(18), .INT_BITS(AT_Q), .FRAC_BITS(0)) u_aspect_div (
      .clock (clock),
      .en    (adv),
      .num   (at_num_ff),
      .den   (at_den_ff),
      .quo   (aterm)
   );

   logic [16:0] u_dly_ff [AT_Q];
   logic [16:0] iou_out_dly_ff [AT_Q];

   always_ff @(posedge clock) begin
      if (adv) begin
         u_dly_ff[0]       <= u_ff;
         iou_out_dly_ff[0] <= iou_ff;
         for (int k = 1; k < AT_Q; k++) begin
            u_dly_ff[k]       <= u_dly_ff[k-1];
            iou_out_dly_ff[k] <= iou_out_dly_ff[k-1];
         end
      end
   end

   // ---------------- sum, saturate, response register ----------------
   logic [19:0] loss_sum;
   assign loss_sum = 20'(u_dly_ff[AT_Q-1]) + 20'(dt_dly_ff[DT_DLY-1]) + 20'(aterm);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= vld_ff[LAST-1];
      end
   end

   // load the response register whenever it is free or being taken
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff.overlap_ratio <= iou_out_dly_ff[AT_Q-1];
         rsp_data_ff.box_loss      <= (loss_sum > 20'(LOSS_CAP)) ? 18'(LOSS_CAP)
                                                                 : loss_sum[17:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/ciou_checker.sv]
`timescale 1ns / 1ps

module ciou_checker import ciou_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input ciou_rsp_type rsp_data
);

   // hold the request side only while a response is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a blocked response");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // loss always contains the 1 - IoU part and stays within range
   a_loss_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.overlap_ratio <= 17'(ONE_Q16)
                     && rsp_data.box_loss <= 18'(LOSS_CAP)
                     && (19'(rsp_data.box_loss) + 19'(rsp_data.overlap_ratio)
                         >= 19'(ONE_Q16))))
      else $error("response out of range");

endmodule

bind ciou_box_loss ciou_checker u_ciou_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/tb_ciou_box_loss.sv]
`timescale 1ns / 1ps

module tb_ciou_box_loss;
   import ciou_pkg::*;

   localparam int  PIPE_DEPTH  = 41;
   localparam int  RAND_ITEMS  = 1450;
   localparam longint CYCLE_CAP = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ciou_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ciou_rsp_type rsp_data;

   ciou_box_loss uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Expected responses, oldest first.
   ciou_rsp_type loss_queue[$];
   int           mismatch_count = 0;
   longint       cycle_count = 0;
   bit           stim_done = 1'b0;
   bit           hold_off_long = 1'b0;

   // Directed rows: boxes plus, where obvious, the typed-in response.
   typedef struct {
      ciou_req_type boxes;
      bit           has_known;
      ciou_rsp_type known;
   } box_row_type;

   box_row_type directed_rows[$];

   // Arithmetic helpers for the predictor.
   function automatic longint unsigned extent(longint unsigned lo, longint unsigned hi);
      return hi > lo ? hi - lo : 0;
   endfunction

   function automatic longint unsigned q16_ratio(longint unsigned num,
                                                 longint unsigned den,
                                                 longint unsigned cap);
      longint unsigned quo, rem, frac, res;
      if (den == 0) return 0;
      quo  = num / den;
      rem  = num % den;
      if (quo > (cap >> 16)) return cap;
      frac = 0;
      for (int k = 0; k < 16; k++) begin
         rem  = rem << 1;
         frac = frac << 1;
         if (rem >= den) begin
            rem  = rem - den;
            frac = frac | 64'd1;
         end
      end
      res = (quo << 16) | frac;
      return res > cap ? cap : res;
   endfunction

   // atan2(w, h), 2^30 is a quarter turn; >>> on signed rounds toward minus infinity.
   function automatic longint box_angle(longint unsigned w, longint unsigned h);
      longint x, y, z, xs, ys;
      if (w == 0 && h == 0) return 0;
      x = longint'(h << CORDIC_GUARD);
      y = longint'(w << CORDIC_GUARD);
      z = 0;
      for (int i = 0; i < ATAN_STEPS_DEFAULT && i < TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(ATAN_TABLE[i]);
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(ATAN_TABLE[i]);
         end
      end
      if (z < 0) z = 0;
      if (z > ANGLE_QUARTER) z = ANGLE_QUARTER;
      return z;
   endfunction

   function automatic ciou_rsp_type predict_loss(ciou_req_type b);
      longint unsigned px1, py1, px2, py2, gx1, gy1, gx2, gy2;
      longint unsigned wp, hp, wg, hg, iw, ih, inter, uni, iou;
      longint unsigned sp, sg, sx, sy, ew, eh, c2, dterm, d, v, u, aden, aterm, loss;
      longint ap, ag;
      ciou_rsp_type r;
      px1 = 64'(b.pred_left);  py1 = 64'(b.pred_top);
      px2 = 64'(b.pred_right); py2 = 64'(b.pred_bottom);
      gx1 = 64'(b.gt_left);    gy1 = 64'(b.gt_top);
      gx2 = 64'(b.gt_right);   gy2 = 64'(b.gt_bottom);
      wp = extent(px1, px2); hp = extent(py1, py2);
      wg = extent(gx1, gx2); hg = extent(gy1, gy2);
      iw = extent(px1 > gx1 ? px1 : gx1, px2 < gx2 ? px2 : gx2);
      ih = extent(py1 > gy1 ? py1 : gy1, py2 < gy2 ? py2 : gy2);
      inter = iw * ih;
      uni   = wp * hp + wg * hg - inter;
      iou   = q16_ratio(inter, uni, ONE_Q16);
      sp = px1 + px2; sg = gx1 + gx2;
      sx = sp > sg ? sp - sg : sg - sp;
      sp = py1 + py2; sg = gy1 + gy2;
      sy = sp > sg ? sp - sg : sg - sp;
      ew = extent(px1 < gx1 ? px1 : gx1, px2 > gx2 ? px2 : gx2);
      eh = extent(py1 < gy1 ? py1 : gy1, py2 > gy2 ? py2 : gy2);
      c2 = ew * ew + eh * eh;
      dterm = q16_ratio(sx * sx + sy * sy, 4 * c2, LOSS_CAP);
      ap = box_angle(wp, hp);
      ag = box_angle(wg, hg);
      d  = longint'(ag > ap ? ag - ap : ap - ag);
      v  = (d * d) >> 44;
      u  = ONE_Q16 - iou;
      aden  = u + v;
      aterm = aden != 0 ? (v * v) / aden : 0;
      loss  = u + dterm + aterm;
      if (loss > LOSS_CAP) loss = LOSS_CAP;
      r.overlap_ratio = iou[16:0];
      r.box_loss      = loss[17:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   function automatic ciou_req_type make_boxes(int a, int b, int c, int d,
                                               int e, int f, int g, int h);
      ciou_req_type x;
      x.pred_left = 16'(a); x.pred_top = 16'(b); x.pred_right = 16'(c);
      x.pred_bottom = 16'(d);
      x.gt_left   = 16'(e); x.gt_top   = 16'(f); x.gt_right   = 16'(g);
      x.gt_bottom   = 16'(h);
      return x;
   endfunction

   task automatic add_row(ciou_req_type b, bit known = 1'b0, int iou = 0, int loss = 0);
      box_row_type row;
      row.boxes = b;
      row.has_known = known;
      row.known.overlap_ratio = 17'(iou);
      row.known.box_loss = 18'(loss);
      directed_rows = {directed_rows, row};
   endtask

   // Random box pair: mostly well-formed boxes, the target often jittered around the prediction; some noise.
   function automatic ciou_req_type random_boxes();
      ciou_req_type b;
      int kind, x1, y1, w, h;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         x1 = $urandom_range(0, 60000); y1 = $urandom_range(0, 60000);
         w = $urandom_range(0, 65535 - x1); h = $urandom_range(0, 65535 - y1);
         b.pred_left = 16'(x1); b.pred_top = 16'(y1);
         b.pred_right = 16'(x1 + w); b.pred_bottom = 16'(y1 + h);
         if (kind < 4) begin
            // target jittered around prediction
            b.gt_left   = 16'(x1 + $urandom_range(0, 2000));
            b.gt_top    = 16'(y1 + $urandom_range(0, 2000));
            b.gt_right  = 16'(b.gt_left + $urandom_range(0, 65535 - b.gt_left));
            b.gt_bottom = 16'(b.gt_top + $urandom_range(0, 65535 - b.gt_top));
         end else begin
            b.gt_left = 16'($urandom_range(0, 60000));
            b.gt_top  = 16'($urandom_range(0, 60000));
            b.gt_right  = 16'(b.gt_left + $urandom_range(0, 65535 - b.gt_left));
            b.gt_bottom = 16'(b.gt_top + $urandom_range(0, 65535 - b.gt_top));
         end
      end else begin
         b = {$urandom, $urandom, $urandom, $urandom};
      end
      return b;
   endfunction

   // Sender.
   task automatic send_boxes(ciou_req_type b);
      req_data  <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      loss_queue = {loss_queue, predict_loss(b)};
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int gap;
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      box_row_type row;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Identical boxes: IoU is one and the loss is zero.
      add_row(make_boxes(100, 200, 300, 400, 100, 200, 300, 400), 1'b1, ONE_Q16, 0);
      // Everything zero: zero union, zero diagonal, both angles zero.
      add_row(make_boxes(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, ONE_Q16);
      // Full-frame boxes.
      add_row(make_boxes(0, 0, 65535, 65535, 0, 0, 65535, 65535), 1'b1, ONE_Q16, 0);
      add_row(make_boxes(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535),
              1'b1, 0, ONE_Q16);
      // Inverted boxes, clamped to zero extent.
      add_row(make_boxes(65535, 65535, 0, 0, 0, 0, 65535, 65535));
      add_row(make_boxes(500, 500, 100, 100, 400, 400, 50, 50));
      // Far apart, disjoint: large distance term.
      add_row(make_boxes(0, 0, 1, 1, 65534, 65534, 65535, 65535));
      add_row(make_boxes(0, 0, 65535, 1, 0, 65534, 1, 65535));
      // Zero height with width: angle goes to a quarter turn.
      add_row(make_boxes(0, 100, 65535, 100, 0, 0, 100, 65535));
      add_row(make_boxes(10, 10, 10, 50000, 10, 10, 50000, 10));
      // Degenerate point versus a real box.
      add_row(make_boxes(300, 300, 300, 300, 100, 100, 900, 700));
      // Partial overlaps, nested boxes.
      add_row(make_boxes(0, 0, 32768, 32768, 16384, 16384, 49152, 49152));
      add_row(make_boxes(1000, 1000, 60000, 60000, 20000, 20000, 30000, 30000));
      add_row(make_boxes(0, 0, 65535, 65535, 32767, 32767, 32768, 32768));
      add_row(make_boxes(16'haaaa, 16'h5555, 16'hffff, 16'hfffe,
                         16'h5555, 16'haaaa, 16'hfffe, 16'hffff));
      add_row(make_boxes(1, 2, 3, 4, 5, 6, 7, 8));

      @(negedge clock);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_boxes(row.boxes);
         // Typed-in value overrides the predicted one for the easy rows.
         if (row.has_known) loss_queue[loss_queue.size() - 1] = row.known;
         sender_gap();
      end

      // Pause until every directed response is back.
      req_valid <= 1'b0;
      while (loss_queue.size() != 0) @(negedge clock);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         // Long receiver hold-off partway in while the sender keeps offering.
         if (n == 400) hold_off_long = 1'b1;
         if (n == 900) begin
            req_valid <= 1'b0;
            while (loss_queue.size() != 0) @(negedge clock);
         end
         send_boxes(random_boxes());
         if (n < 400 || n > 520) sender_gap();
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // Receiver stall: random gaps, plus one long stretch counted here.
   initial begin
      int hold;
      bit long_done;
      long_done = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_long && !long_done) begin
            long_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
         end
         hold = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 50)
              : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
         if ($urandom_range(0, 1) == 0 && cycle_count > 3000 && cycle_count < 6000)
            hold = 0;
         rsp_stall <= (hold != 0);
         repeat (hold != 0 ? hold : 1) @(negedge clock);
      end
   end

   // Checker: compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      ciou_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (loss_queue.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_data), 0);
         end else begin
            want = loss_queue.pop_front();
            if (rsp_data.overlap_ratio !== want.overlap_ratio)
               report_mismatch("overlap_ratio", 64'(rsp_data.overlap_ratio),
                               64'(want.overlap_ratio));
            if (rsp_data.box_loss !== want.box_loss)
               report_mismatch("box_loss", 64'(rsp_data.box_loss), 64'(want.box_loss));
         end
      end
   end

   // End of run: drain, then linger past the pipeline depth, with a cap.
   initial begin
      wait (stim_done);
      while (loss_queue.size() != 0 && cycle_count < CYCLE_CAP) @(negedge clock);
      repeat (4 * PIPE_DEPTH) @(negedge clock);
      if (mismatch_count == 0 && loss_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      wait (cycle_count >= CYCLE_CAP);
      $display("Some tests failed");
      $finish;
   end

endmodule
